### rtl/core/htfc_pkg.sv
// Shared types, constants and the CRC-8 byte update for the frame checker.
package htfc_pkg;

  localparam logic [7:0]  CRC_POLY    = 8'h31;
  localparam logic [7:0]  CRC_INIT    = 8'hFF;
  localparam logic [15:0] FAIL_ID     = 16'hFFFF;
  localparam logic [2:0]  MEAS_LEN    = 3'd6;
  localparam logic [2:0]  ID_LEN      = 3'd3;
  localparam logic [14:0] TEMP_SCALE  = 15'd17500;
  localparam logic [13:0] HUM_SCALE   = 14'd10000;
  localparam logic [14:0] TEMP_OFFSET = 15'd4500;

  // configuration register indexes
  localparam logic CFG_CRC_EN     = 1'b0;
  localparam logic CFG_FRAME_KIND = 1'b1;

  typedef enum logic {
    KIND_MEAS = 1'b0,
    KIND_ID   = 1'b1
  } frame_kind_t;

  // one finished frame, still in raw form
  typedef struct packed {
    logic        ok;
    frame_kind_t kind;
    logic [15:0] word0;
    logic [15:0] word1;
  } frame_result_t;

  typedef struct packed {
    logic          valid;
    frame_result_t data;
  } result_push_t;

  // CRC-8, MSB first, one byte
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

endpackage

### rtl/core/htfc_front.sv
// Front end: config registers, byte tracking, CRC check and result push.
module htfc_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic                  cfg_addr,
  input  logic                  cfg_data,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  logic [7:0]            rx_byte,
  input  logic                  frame_start,
  input  logic                  bus_fail,
  output htfc_pkg::result_push_t push
);

  logic                  crc_en;
  htfc_pkg::frame_kind_t kind;
  logic [2:0]            pos;
  logic [7:0]            crc;
  logic                  mism;
  logic [15:0]           w0;
  logic [15:0]           w1;

  logic        in_fire;
  logic [2:0]  len;
  logic        restart;
  logic [2:0]  pos_eff;
  logic [7:0]  crc_eff;
  logic        mism_eff;
  logic        is_crc;
  logic        is_high;
  logic        last;
  logic [7:0]  crc_next;
  logic        mism_next;
  logic [15:0] w0_next;
  logic [15:0] w1_next;

  assign in_fire = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      crc_en <= 1'b1;
      kind   <= htfc_pkg::KIND_MEAS;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        htfc_pkg::CFG_CRC_EN:     crc_en <= cfg_data;
        htfc_pkg::CFG_FRAME_KIND: kind   <= htfc_pkg::frame_kind_t'(cfg_data);
      endcase
    end
  end

  always_comb begin
    len      = (kind == htfc_pkg::KIND_ID) ? htfc_pkg::ID_LEN : htfc_pkg::MEAS_LEN;
    // a kind change can leave the position past the new end: start over
    restart  = frame_start || (pos >= len);
    pos_eff  = restart ? 3'd0 : pos;
    crc_eff  = restart ? htfc_pkg::CRC_INIT : crc;
    mism_eff = restart ? 1'b0 : mism;
    is_crc   = (pos_eff == 3'd2) || (pos_eff == 3'd5);
    is_high  = (pos_eff == 3'd0) || (pos_eff == 3'd3);
    last     = (pos_eff == (len - 3'd1));

    w0_next   = w0;
    w1_next   = w1;
    mism_next = mism_eff;
    if (is_crc) begin
      mism_next = mism_eff | (crc_en && (crc_eff != rx_byte));
      crc_next  = htfc_pkg::CRC_INIT;
    end else begin
      crc_next = htfc_pkg::crc8_byte(crc_eff, rx_byte);
      if (pos_eff < 3'd3) begin
        w0_next = is_high ? {rx_byte, w0[7:0]} : {w0[15:8], rx_byte};
      end else begin
        w1_next = is_high ? {rx_byte, w1[7:0]} : {w1[15:8], rx_byte};
      end
    end

    push.valid      = in_fire && (bus_fail || last);
    push.data.ok    = !bus_fail && !mism_next;
    push.data.kind  = kind;
    push.data.word0 = w0_next;
    push.data.word1 = w1_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos  <= 3'd0;
      crc  <= htfc_pkg::CRC_INIT;
      mism <= 1'b0;
      w0   <= 16'd0;
      w1   <= 16'd0;
    end else if (in_fire) begin
      if (bus_fail || last) begin
        pos  <= 3'd0;
        crc  <= htfc_pkg::CRC_INIT;
        mism <= 1'b0;
      end else begin
        pos  <= pos_eff + 3'd1;
        crc  <= crc_next;
        mism <= mism_next;
      end
      if (!bus_fail) begin
        w0 <= w0_next;
        w1 <= w1_next;
      end
    end
  end

  // the position never runs past the longest frame
  a_pos_range: assert property (@(posedge clk) disable iff (rst) pos < htfc_pkg::MEAS_LEN)
    else $error("byte position out of range");

  // a byte at the CRC slot leaves the running CRC at its initial value
  a_crc_reload: assert property (@(posedge clk) disable iff (rst)
    in_fire && !bus_fail && is_crc |=> crc == htfc_pkg::CRC_INIT)
    else $error("running CRC not reloaded after CRC byte");

endmodule

### rtl/core/htfc_queue.sv
// Short result queue between front end and scaling back end.
module htfc_queue #(
  parameter int DEPTH = 2
) (
  input  logic                    clk,
  input  logic                    rst,
  input  htfc_pkg::result_push_t  push,
  output logic                    full,
  output logic                    q_valid,
  output htfc_pkg::frame_result_t q_data,
  input  logic                    q_pop
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  htfc_pkg::frame_result_t entry [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  logic do_push;
  logic do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign q_valid = (count != '0);
  assign q_data  = entry[rd_ptr];
  assign do_push = push.valid && !full;
  assign do_pop  = q_pop && q_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry[wr_ptr] <= push.data;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) !(push.valid && full))
    else $error("result pushed into full queue");

  a_count_range: assert property (@(posedge clk) disable iff (rst) count <= CNT_W'(DEPTH))
    else $error("queue count out of range");

endmodule

### rtl/core/htfc_scale.sv
// Back end: two-stage scaling of raw words into centi units, output register.
module htfc_scale (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    q_valid,
  input  htfc_pkg::frame_result_t q_data,
  output logic                    q_pop,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic                    ok,
  output logic                    frame_type,
  output logic signed [14:0]      temperature_centi,
  output logic [13:0]             humidity_centi,
  output logic [15:0]             device_id
);

  logic                  s1_valid;
  logic                  s1_ok;
  htfc_pkg::frame_kind_t s1_kind;
  logic [15:0]           s1_w0;
  logic [30:0]           s1_tprod;
  logic [29:0]           s1_hprod;

  logic        out_adv;
  logic        s1_adv;
  logic [31:0] t_sum;
  logic [30:0] h_sum;
  logic [14:0] t_quot;
  logic [13:0] h_quot;
  logic [14:0] t_diff;
  logic        ok_meas;

  assign out_adv = !out_valid || out_ready;
  assign s1_adv  = !s1_valid || out_adv;
  assign q_pop   = q_valid && s1_adv;

  // x / 65535 == (x + (x >> 16) + 1) >> 16 while the quotient stays below 2^16
  always_comb begin
    t_sum   = {1'b0, s1_tprod} + 32'(s1_tprod >> 16) + 32'd1;
    h_sum   = {1'b0, s1_hprod} + 31'(s1_hprod >> 16) + 31'd1;
    t_quot  = t_sum[30:16];
    h_quot  = h_sum[29:16];
    t_diff  = t_quot - htfc_pkg::TEMP_OFFSET;
    ok_meas = s1_ok && (s1_kind == htfc_pkg::KIND_MEAS);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s1_adv) begin
        s1_valid <= q_valid;
      end
      if (out_adv) begin
        out_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      s1_ok    <= q_data.ok;
      s1_kind  <= q_data.kind;
      s1_w0    <= q_data.word0;
      s1_tprod <= 31'(q_data.word0) * 31'(htfc_pkg::TEMP_SCALE);
      s1_hprod <= 30'(q_data.word1) * 30'(htfc_pkg::HUM_SCALE);
    end
    if (out_adv && s1_valid) begin
      ok                <= s1_ok;
      frame_type        <= logic'(s1_kind);
      temperature_centi <= ok_meas ? $signed(t_diff) : 15'sd0;
      humidity_centi    <= ok_meas ? h_quot : 14'd0;
      if (s1_kind == htfc_pkg::KIND_ID) begin
        device_id <= s1_ok ? s1_w0 : htfc_pkg::FAIL_ID;
      end else begin
        device_id <= 16'd0;
      end
    end
  end

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !ok |-> temperature_centi == 15'sd0 && humidity_centi == 14'd0)
    else $error("failed result carries a measurement");

  a_id_no_meas: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_type |-> temperature_centi == 15'sd0 && humidity_centi == 14'd0)
    else $error("identifier result carries a measurement");

endmodule

### rtl/core/humidity_temp_frame_checker.sv
// Top level of the sensor frame checker: CRC-8 word check and centi-unit scaling.
//
//  channel  | handshake            | payload
//  ---------+----------------------+-----------------------------------------------
//  cfg      | cfg_we               | cfg_addr (register), cfg_data
//  in       | in_valid / in_ready  | rx_byte, frame_start, bus_fail
//  out      | out_valid / out_ready| ok, frame_type, temperature_centi,
//           |                      | humidity_centi, device_id
//
// One byte transfer per cycle while the result queue has room. A frame's result
// is written to the queue by the byte transfer that ends the frame, then
// multiplied, then divided into the output register.
// Reset (synchronous, rst high) sets CRC check on, measurement frames, empty
// frame and queue. in_ready drops only when the result queue is full; the
// queue plus the two back-end stages absorb QUEUE_DEPTH + 2 results under
// an output stall before the front end stops taking bytes.
module humidity_temp_frame_checker #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic               clk,
  input  logic               rst,
  // configuration writes
  input  logic               cfg_we,
  input  logic               cfg_addr,
  input  logic               cfg_data,
  // byte input
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         rx_byte,
  input  logic               frame_start,
  input  logic               bus_fail,
  // results
  output logic               out_valid,
  input  logic               out_ready,
  output logic               ok,
  output logic               frame_type,
  output logic signed [14:0] temperature_centi,
  output logic [13:0]        humidity_centi,
  output logic [15:0]        device_id
);

  htfc_pkg::result_push_t  push;
  htfc_pkg::frame_result_t q_data;
  logic                    q_full;
  logic                    q_valid;
  logic                    q_pop;

  // a byte may finish a frame, so room for one result is required
  assign in_ready = !q_full;

  // front: tracks byte position, running CRC, mismatch flag and the two words
  htfc_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_addr    (cfg_addr),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .rx_byte     (rx_byte),
    .frame_start (frame_start),
    .bus_fail    (bus_fail),
    .push        (push)
  );

  // decouples the byte stream from result delivery
  htfc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .full    (q_full),
    .q_valid (q_valid),
    .q_data  (q_data),
    .q_pop   (q_pop)
  );

  // back: multiply by the scale, divide by 65535, output register
  htfc_scale u_scale (
    .clk               (clk),
    .rst               (rst),
    .q_valid           (q_valid),
    .q_data            (q_data),
    .q_pop             (q_pop),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .ok                (ok),
    .frame_type        (frame_type),
    .temperature_centi (temperature_centi),
    .humidity_centi    (humidity_centi),
    .device_id         (device_id)
  );

endmodule

### bench/testbench.sv
// Self-checking bench for humidity_temp_frame_checker: byte-level frame checks and scaling.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // One expected result as the block should present it on its output port.
  typedef struct {
    logic                  ok;
    htfc_pkg::frame_kind_t kind;
    logic signed [14:0]    temp;
    logic [13:0]           hum;
    logic [15:0]           id;
  } frame_expect_t;

  // Scoreboard: tracks the frame state and the register copies, predicts a
  // result for each accepted byte that ends or aborts a frame, and checks
  // the block's results in order against those predictions.
  class frame_result_board;
    bit                    crc_en;
    htfc_pkg::frame_kind_t kind;
    logic [2:0]            pos;
    logic [7:0]            crc;
    logic [15:0]           w0;
    logic [15:0]           w1;
    bit                    bad;
    frame_expect_t         expected[$];
    int                    errors;

    function new();
      crc_en = 1'b1;
      kind   = htfc_pkg::KIND_MEAS;
      pos    = '0;
      crc    = htfc_pkg::CRC_INIT;
      w0     = '0;
      w1     = '0;
      bad    = 1'b0;
      errors = 0;
    endfunction

    // CRC-8, MSB first, one byte
    static function logic [7:0] crc_step(input logic [7:0] c_in, input logic [7:0] b);
      logic [7:0] c;
      c = c_in ^ b;
      for (int k = 0; k < 8; k++) begin
        if (c[7]) c = (c << 1) ^ htfc_pkg::CRC_POLY;
        else      c = c << 1;
      end
      return c;
    endfunction

    function void write_reg(input logic addr, input logic data);
      if (addr == htfc_pkg::CFG_CRC_EN) crc_en = data;
      else                              kind   = htfc_pkg::frame_kind_t'(data);
    endfunction

    function void restart_frame();
      pos = '0;
      crc = htfc_pkg::CRC_INIT;
      bad = 1'b0;
    endfunction

    function void push_result(input bit good, input logic [15:0] a, input logic [15:0] b);
      frame_expect_t e;
      int unsigned   t;
      int unsigned   h;
      e.ok   = good;
      e.kind = kind;
      e.temp = '0;
      e.hum  = '0;
      e.id   = '0;
      if (kind == htfc_pkg::KIND_ID) begin
        e.id = good ? a : htfc_pkg::FAIL_ID;
      end else if (good) begin
        t = (32'(htfc_pkg::TEMP_SCALE) * 32'(a)) / 32'd65535;
        h = (32'(htfc_pkg::HUM_SCALE) * 32'(b)) / 32'd65535;
        e.temp = 15'(t - 32'(htfc_pkg::TEMP_OFFSET));
        e.hum  = 14'(h);
      end
      expected.push_back(e);
    endfunction

    function void note_byte(input logic [7:0] b, input logic fs, input logic bf);
      logic [2:0] len;
      logic [2:0] p;
      logic [1:0] slot;
      len = (kind == htfc_pkg::KIND_ID) ? htfc_pkg::ID_LEN : htfc_pkg::MEAS_LEN;
      // a bus failure wins over everything, the byte itself is dropped
      if (bf) begin
        restart_frame();
        push_result(1'b0, '0, '0);
        return;
      end
      // explicit start, or the kind shrank under a frame already too long
      if (fs || pos >= len) restart_frame();
      p    = pos;
      slot = 2'(p % 3);
      if (slot == 2'd2) begin
        if (crc_en && crc != b) bad = 1'b1;
        crc = htfc_pkg::CRC_INIT;
      end else begin
        crc = crc_step(crc, b);
        if (p < 3) begin
          if (slot == 2'd0) w0[15:8] = b;
          else              w0[7:0]  = b;
        end else begin
          if (slot == 2'd0) w1[15:8] = b;
          else              w1[7:0]  = b;
        end
      end
      if (p == len - 3'd1) begin
        push_result(!bad, w0, w1);
        restart_frame();
        return;
      end
      pos = p + 3'd1;
    endfunction

    function int pending();
      return expected.size();
    endfunction

    function void compare_field(input string name, input int want, input int got);
      if (want != got) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(input logic ok_q, input logic type_q,
                               input logic signed [14:0] temp_q,
                               input logic [13:0] hum_q, input logic [15:0] id_q);
      frame_expect_t e;
      if (expected.size() == 0) begin
        $error("result transfer with no frame result pending");
        errors++;
        return;
      end
      e = expected.pop_front();
      compare_field("ok", int'(e.ok), int'(ok_q));
      compare_field("frame_type", int'(e.kind), int'(type_q));
      compare_field("temperature_centi", int'(e.temp), int'(temp_q));
      compare_field("humidity_centi", int'(e.hum), int'(hum_q));
      compare_field("device_id", int'(e.id), int'(id_q));
    endfunction
  endclass

  // Cycles with no transfer on either channel before the run is declared hung.
  // A receiver stall at 57 percent, or the settle time around a register
  // write, stays far below this.
  localparam int STALL_LIMIT = 4000;
  // Bytes per random phase; six phases give about 1900 bytes in all.
  localparam int PHASE_BYTES = 310;

  logic               clk;
  logic               rst;
  logic               cfg_we;
  logic               cfg_addr;
  logic               cfg_data;
  logic               in_valid;
  logic               in_ready;
  logic [7:0]         rx_byte;
  logic               frame_start;
  logic               bus_fail;
  logic               out_valid;
  logic               out_ready;
  logic               ok;
  logic               frame_type;
  logic signed [14:0] temperature_centi;
  logic [13:0]        humidity_centi;
  logic [15:0]        device_id;

  frame_result_board sb = new();

  int send_idle_pct;
  int recv_idle_pct;
  int bytes_sent;
  int quiet_cycles;

  humidity_temp_frame_checker i_dut (
    .clk               (clk),
    .rst               (rst),
    .cfg_we            (cfg_we),
    .cfg_addr          (cfg_addr),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .rx_byte           (rx_byte),
    .frame_start       (frame_start),
    .bus_fail          (bus_fail),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .ok                (ok),
    .frame_type        (frame_type),
    .temperature_centi (temperature_centi),
    .humidity_centi    (humidity_centi),
    .device_id         (device_id)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Receiver side: ready is redrawn on every falling edge so that stalls land
  // on every phase of the block's two-stage back end.
  always @(negedge clk) begin
    out_ready = ($urandom_range(99) >= recv_idle_pct);
  end

  // Result checking, sampled at the rising edge of each result transfer.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      sb.check_result(ok, frame_type, temperature_centi, humidity_centi, device_id);
    end
  end

  // Watchdog: any transfer on either channel counts as progress.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
    else                                                     quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // One byte transfer. Payload moves on the falling edge; valid stays up with
  // the payload frozen until the rising edge where ready is seen.
  task automatic send_byte(input logic [7:0] b, input logic fs, input logic bf);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid    = 1'b1;
    rx_byte     = b;
    frame_start = fs;
    bus_fail    = bf;
    do @(posedge clk); while (!in_ready);
    sb.note_byte(b, fs, bf);
    bytes_sent++;
  endtask

  // Word high byte first, then its CRC, optionally corrupted.
  task automatic send_word(input logic [15:0] w, input bit good_crc, input logic fs);
    logic [7:0] c;
    c = frame_result_board::crc_step(htfc_pkg::CRC_INIT, w[15:8]);
    c = frame_result_board::crc_step(c, w[7:0]);
    if (!good_crc) c = c ^ 8'(1 << $urandom_range(7));
    send_byte(w[15:8], fs, 1'b0);
    send_byte(w[7:0], 1'b0, 1'b0);
    send_byte(c, 1'b0, 1'b0);
  endtask

  task automatic write_cfg(input logic addr, input logic data);
    @(negedge clk);
    cfg_we   = 1'b1;
    cfg_addr = addr;
    cfg_data = data;
    @(posedge clk);
    sb.write_reg(addr, data);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Stop sending, wait out every pending result, then let the clock run on
  // so nothing is still in flight before the registers change.
  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Mostly well-formed frames with random words, plus noise, truncation,
  // restarts mid-frame, bad CRC bytes and bus failures. upto caps the byte
  // count so a phase can end inside a frame.
  task automatic send_random_frame(input int upto);
    logic [7:0]  fb[6];
    logic [15:0] w;
    logic [7:0]  c;
    int          len;
    int          n;
    int          sel;
    logic        fs;
    logic        bf;
    sel = $urandom_range(99);
    if (sel < 5) begin
      // loose noise bytes
      n = $urandom_range(1, 7);
      if (n > upto) n = upto;
      for (int i = 0; i < n; i++) begin
        send_byte(8'($urandom_range(255)), ($urandom_range(9) == 0),
                  ($urandom_range(19) == 0));
      end
      return;
    end
    len = (sb.kind == htfc_pkg::KIND_ID) ? 3 : 6;
    for (int k = 0; k < 2; k++) begin
      sel = $urandom_range(9);
      if (sel == 0)      w = 16'h0000;
      else if (sel == 1) w = 16'hFFFF;
      else               w = 16'($urandom_range(65535));
      c = frame_result_board::crc_step(htfc_pkg::CRC_INIT, w[15:8]);
      c = frame_result_board::crc_step(c, w[7:0]);
      if ($urandom_range(99) < 12) c = c ^ 8'($urandom_range(1, 255));
      fb[3*k]     = w[15:8];
      fb[3*k + 1] = w[7:0];
      fb[3*k + 2] = c;
    end
    n = len;
    if ($urandom_range(99) < 5) n = $urandom_range(1, len - 1);
    if (n > upto) n = upto;
    for (int i = 0; i < n; i++) begin
      fs = (i == 0) ? ($urandom_range(9) != 0) : ($urandom_range(49) == 0);
      bf = ($urandom_range(39) == 0);
      send_byte(fb[i], fs, bf);
      if (bf) break;
    end
  endtask

  initial begin
    bit cfg_crc[6];
    bit cfg_kind[6];
    cfg_crc  = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1};
    cfg_kind = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1};

    rst           = 1'b1;
    cfg_we        = 1'b0;
    cfg_addr      = htfc_pkg::CFG_CRC_EN;
    cfg_data      = 1'b0;
    in_valid      = 1'b0;
    rx_byte       = '0;
    frame_start   = 1'b0;
    bus_fail      = 1'b0;
    out_ready     = 1'b0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    bytes_sent    = 0;
    quiet_cycles  = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // ---- directed part ----
    write_cfg(htfc_pkg::CFG_CRC_EN, 1'b1);
    write_cfg(htfc_pkg::CFG_FRAME_KIND, htfc_pkg::KIND_MEAS);
    // coldest reading and full humidity, then hottest reading with a bad CRC
    send_word(16'h0000, 1'b1, 1'b1);
    send_word(16'hFFFF, 1'b1, 1'b0);
    send_word(16'hFFFF, 1'b1, 1'b1);
    send_word(16'h0000, 1'b0, 1'b0);
    // bus failure together with frame start: failure wins
    send_byte(8'hA5, 1'b1, 1'b1);
    // leave a measurement frame two bytes in, then switch to identifier
    // frames with the check off; the next byte lands on the CRC slot and
    // closes an identifier frame from the old bytes
    send_byte(8'h12, 1'b1, 1'b0);
    send_byte(8'h34, 1'b0, 1'b0);
    drain();
    write_cfg(htfc_pkg::CFG_CRC_EN, 1'b0);
    write_cfg(htfc_pkg::CFG_FRAME_KIND, htfc_pkg::KIND_ID);
    send_byte(8'h00, 1'b0, 1'b0);
    // bad CRC ignored while checking is off, then flagged once it is on
    send_word(16'hBEEF, 1'b0, 1'b1);
    drain();
    write_cfg(htfc_pkg::CFG_CRC_EN, 1'b1);
    send_word(16'hBEEF, 1'b0, 1'b1);
    // measurement frame stopped four bytes in; with identifier frames the
    // position is past the end, so the next byte opens a new frame
    drain();
    write_cfg(htfc_pkg::CFG_FRAME_KIND, htfc_pkg::KIND_MEAS);
    send_word(16'h6666, 1'b1, 1'b1);
    send_byte(8'h80, 1'b0, 1'b0);
    drain();
    write_cfg(htfc_pkg::CFG_FRAME_KIND, htfc_pkg::KIND_ID);
    send_word(16'hFFFF, 1'b1, 1'b0);
    drain();

    // ---- random part: three idle profiles, two register settings each ----
    for (int ph = 0; ph < 6; ph++) begin
      case (ph / 2)
        0: begin
          send_idle_pct = 37;
          recv_idle_pct = 57;
        end
        1: begin
          send_idle_pct = 57;
          recv_idle_pct = 37;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      write_cfg(htfc_pkg::CFG_CRC_EN, cfg_crc[ph]);
      write_cfg(htfc_pkg::CFG_FRAME_KIND, cfg_kind[ph]);
      bytes_sent = 0;
      while (bytes_sent < PHASE_BYTES) send_random_frame(6);
      // send up to five more bytes, so the phase may end inside a frame for the next setting
      send_random_frame($urandom_range(0, 5));
      drain();
    end

    // drain() already waited out the pipeline after the last result
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
